/* src/rma_pkg.sv */
// Shared types and constants for the region map allocator.
package rma_pkg;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CUT   = 2'd1;
  localparam logic [1:0] REQ_ALLOC = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_SLOT = 2'd1;
  localparam logic [1:0] ST_NO_FIT  = 2'd2;

  localparam logic [31:0] LIMIT_RESET = 32'hFFFFF000;
  localparam logic [39:0] TOTAL_MAX   = 40'hFF_FFFF_FFFF;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] length;
  } region_t;

endpackage

/* src/region_map_allocator_top.sv */
// Top level of the region map allocator: request sequencer around the region table.
//
// The block keeps a table of free physical regions in a single-port-read,
// single-port-write memory and serves one request transaction at a time. A
// transaction is taken when start is high and busy is low; busy then stays
// high until the result appears on the result ports for exactly one cycle,
// marked by done. The receiver cannot stall, so a result must be captured in
// the cycle done is high. After reset the block first sweeps the table to
// clear it with busy high; address_limit writes are taken at any time. Every
// table visit is one memory read followed by a check of its registered data,
// so an add visits the slots up to the first empty one, an allocate the slots
// up to the first fit, and a cut every slot in use plus the scans of up to
// two re-adds for every region it splits.
module region_map_allocator_top #(
  parameter int TABLE_ENTRIES = 32,
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] base_addr,
  input  logic [31:0] size_bytes,
  input  logic [31:0] end_addr,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] alloc_addr,
  output logic [31:0] high_mark,
  output logic [39:0] allocated_total
);
  import rma_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int PG_W = $clog2(PAGE_BYTES);
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);
  localparam logic [32:0] PAGE_C = 33'(PAGE_BYTES);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_AREAD   = 4'd2;  // add: read slot
  localparam logic [3:0] S_ACHECK  = 4'd3;  // add: test slot, write
  localparam logic [3:0] S_CREAD   = 4'd4;  // cut: read slot
  localparam logic [3:0] S_CCHECK  = 4'd5;  // cut: test overlap
  localparam logic [3:0] S_CPIECE  = 4'd6;  // cut: launch leftover adds
  localparam logic [3:0] S_LREAD   = 4'd7;  // allocate: read slot
  localparam logic [3:0] S_LCHECK  = 4'd8;  // allocate: test and write
  localparam logic [3:0] S_ADDPREP = 4'd9;  // add: clip and round
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0] state;
  logic [31:0] address_limit;

  // Memory port signals.
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  region_t          rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  region_t          wr_data;

  rma_table #(.ENTRIES(TABLE_ENTRIES), .IDX_W(IDX_W)) u_table (
    .clk(clk), .rd_en(rd_en), .rd_idx(rd_idx), .rd_data(rd_data),
    .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
  );

  // Request and scan registers.
  logic [32:0]       cut_lo, cut_hi;     // page-widened cut range
  logic [32:0]       need;               // page-rounded allocate size
  logic [CNT_W-1:0]  scan;               // cut / allocate slot index
  logic [CNT_W-1:0]  aslot;              // add slot index
  logic [32:0]       add_addr, add_len;  // raw add request
  logic [31:0]       ins_base, ins_len;  // rounded region to store
  logic              pend_hi;            // upper cut piece still to add
  logic [32:0]       hi_addr, hi_len;
  logic              in_cut;             // add runs on behalf of a cut
  logic [1:0]        st;
  logic [31:0]       res_addr;
  logic [CNT_W-1:0]  in_use;
  logic [31:0]       highest_end;
  logic [39:0]       total;

  // Add preparation: clip, round base up, trim to 2^32, round length down.
  logic [32:0] lim33, len_c, base_up, len_t, end33;
  logic        add_skip;
  always_comb begin
    lim33 = {1'b0, address_limit};
    len_c = add_len;
    if (add_addr + add_len > lim33) begin
      len_c = lim33 - add_addr;
    end
    base_up = add_addr;
    if (add_addr[PG_W-1:0] != '0) begin
      base_up = {add_addr[32:PG_W], {PG_W{1'b0}}} + PAGE_C;
    end
    len_t = len_c;
    if (base_up + len_c > 33'h1_0000_0000) begin
      len_t = 33'h1_0000_0000 - base_up;
    end
    add_skip = (add_addr > lim33) || (len_c == '0) || base_up[32];
    end33 = {1'b0, ins_base} + {1'b0, ins_len};
  end

  // Cut overlap arithmetic on the slot just read.
  logic [32:0] mb, me, olo, ohi;
  always_comb begin
    mb = {1'b0, rd_data.base};
    me = mb + {1'b0, rd_data.length};
    olo = (cut_lo < mb) ? mb : cut_lo;
    ohi = (cut_hi > me) ? me : cut_hi;
  end

  logic [40:0] total_sum;
  assign total_sum = {1'b0, total} + {8'd0, need};

  always_comb begin
    rd_en = 1'b0;
    rd_idx = '0;
    wr_en = 1'b0;
    wr_idx = '0;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_idx = scan[IDX_W-1:0];
      end
      S_AREAD: begin
        rd_en = 1'b1;
        rd_idx = aslot[IDX_W-1:0];
      end
      S_ACHECK: begin
        if (rd_data.length == '0) begin
          wr_en = 1'b1;
          wr_idx = aslot[IDX_W-1:0];
          wr_data.base = ins_base;
          wr_data.length = ins_len;
        end
      end
      S_CREAD, S_LREAD: begin
        rd_en = 1'b1;
        rd_idx = scan[IDX_W-1:0];
      end
      S_CCHECK: begin
        if (olo < ohi) begin
          wr_en = 1'b1;
          wr_idx = scan[IDX_W-1:0];
        end
      end
      S_LCHECK: begin
        if ({1'b0, rd_data.length} >= need) begin
          wr_en = 1'b1;
          wr_idx = scan[IDX_W-1:0];
          wr_data.base = rd_data.base + need[31:0];
          wr_data.length = rd_data.length - need[31:0];
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      scan <= '0;
      address_limit <= LIMIT_RESET;
      in_use <= '0;
      highest_end <= '0;
      total <= '0;
      done <= 1'b0;
      pend_hi <= 1'b0;
      in_cut <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        address_limit <= cfg_wdata;
      end
      case (state)
        S_CLEAR: begin
          if (scan == ENTRIES_C - 1'b1) begin
            state <= S_IDLE;
          end
          scan <= scan + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            st <= ST_OK;
            res_addr <= '0;
            scan <= '0;
            in_cut <= 1'b0;
            pend_hi <= 1'b0;
            add_addr <= {1'b0, base_addr};
            add_len <= {1'b0, size_bytes};
            cut_lo <= {1'b0, base_addr[31:PG_W], {PG_W{1'b0}}};
            if (end_addr[PG_W-1:0] != '0) begin
              cut_hi <= {1'b0, end_addr[31:PG_W], {PG_W{1'b0}}} + PAGE_C;
            end else begin
              cut_hi <= {1'b0, end_addr};
            end
            if (size_bytes[PG_W-1:0] != '0) begin
              need <= {1'b0, size_bytes[31:PG_W], {PG_W{1'b0}}} + PAGE_C;
            end else begin
              need <= {1'b0, size_bytes};
            end
            case (req_type)
              REQ_ADD:   state <= S_ADDPREP;
              REQ_CUT:   state <= S_CREAD;
              REQ_ALLOC: state <= S_LREAD;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_ADDPREP: begin
          aslot <= '0;
          ins_base <= base_up[31:0];
          ins_len <= {len_t[31:PG_W], {PG_W{1'b0}}};
          if (add_skip) begin
            state <= in_cut ? S_CPIECE : S_DONE;
          end else begin
            state <= S_AREAD;
          end
        end
        S_AREAD: state <= S_ACHECK;
        S_ACHECK: begin
          if (rd_data.length == '0) begin
            if (aslot >= in_use) begin
              in_use <= aslot + 1'b1;
            end
            if (end33[32]) begin
              highest_end <= '1;
            end else if (end33[31:0] > highest_end) begin
              highest_end <= end33[31:0];
            end
            state <= in_cut ? S_CPIECE : S_DONE;
          end else if (aslot == ENTRIES_C - 1'b1) begin
            st <= ST_NO_SLOT;
            state <= in_cut ? S_CPIECE : S_DONE;
          end else begin
            aslot <= aslot + 1'b1;
            state <= S_AREAD;
          end
        end
        S_CREAD: begin
          if (scan >= in_use || scan == ENTRIES_C) begin
            state <= S_DONE;
          end else begin
            state <= S_CCHECK;
          end
        end
        S_CCHECK: begin
          if (olo < ohi) begin
            pend_hi <= ohi < me;
            hi_addr <= ohi;
            hi_len <= me - ohi;
            in_cut <= 1'b1;
            if (olo > mb) begin
              add_addr <= mb;
              add_len <= olo - mb;
              state <= S_ADDPREP;
            end else begin
              state <= S_CPIECE;
            end
          end else begin
            scan <= scan + 1'b1;
            state <= S_CREAD;
          end
        end
        S_CPIECE: begin
          if (pend_hi) begin
            pend_hi <= 1'b0;
            add_addr <= hi_addr;
            add_len <= hi_len;
            state <= S_ADDPREP;
          end else begin
            scan <= scan + 1'b1;
            state <= S_CREAD;
          end
        end
        S_LREAD: begin
          if (scan >= in_use || scan == ENTRIES_C) begin
            st <= ST_NO_FIT;
            state <= S_DONE;
          end else begin
            state <= S_LCHECK;
          end
        end
        S_LCHECK: begin
          if ({1'b0, rd_data.length} >= need) begin
            res_addr <= rd_data.base;
            total <= total_sum[40] ? TOTAL_MAX : total_sum[39:0];
            state <= S_DONE;
          end else begin
            scan <= scan + 1'b1;
            state <= S_LREAD;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status = st;
  assign alloc_addr = res_addr;
  assign high_mark = highest_end;
  assign allocated_total = total;

`ifndef ASSERT_OFF
  a_done_from_done_state: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_DONE) else $error("done without finishing state");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy while result shown");
  a_in_use_bound: assert property (@(posedge clk) disable iff (rst)
    in_use <= ENTRIES_C) else $error("entry count past table size");
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> total >= $past(total)) else $error("allocated total went down");
`endif

endmodule

/* src/rma_table.sv */
// Region table memory: one write port, one registered read port; the top level clears it in its sweep state.
module rma_table #(
  parameter int ENTRIES = 32,
  parameter int IDX_W = 5
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_idx,
  output rma_pkg::region_t     rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  rma_pkg::region_t     wr_data
);
  import rma_pkg::*;

  region_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

/* bench/region_map_allocator_top_tb.sv */
// Self-checking testbench for the region map allocator top level.
`timescale 1ns / 1ps

module region_map_allocator_top_tb;
  import rma_pkg::*;

  localparam int N_SLOTS = 32;
  localparam longint unsigned PAGE = 4096;
  localparam logic [63:0] ADDR_TOP = 64'hFFFF_FFFF;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [31:0] base_addr;
  logic [31:0] size_bytes;
  logic [31:0] end_addr;
  logic        done;
  logic [1:0]  status;
  logic [31:0] alloc_addr;
  logic [31:0] high_mark;
  logic [39:0] allocated_total;

  region_map_allocator_top #(
    .TABLE_ENTRIES(N_SLOTS),
    .PAGE_BYTES(4096)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .base_addr(base_addr),
    .size_bytes(size_bytes),
    .end_addr(end_addr),
    .done(done),
    .status(status),
    .alloc_addr(alloc_addr),
    .high_mark(high_mark),
    .allocated_total(allocated_total)
  );

  // One result as the block reports it.
  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] addr;
    logic [31:0] high;
    logic [39:0] total;
  } outcome_t;

  // A row of the directed table. When known is set, the expected result is
  // typed in by hand; otherwise the shadow table supplies it.
  typedef struct {
    logic [1:0]  req;
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] stop;
    bit          known;
    outcome_t    res;
  } directed_row_t;

  // Shadow copy of the region table and its bookkeeping.
  logic [31:0] limit_shadow;
  logic [31:0] shadow_base [N_SLOTS];
  logic [31:0] shadow_len [N_SLOTS];
  int unsigned shadow_used;
  logic [31:0] shadow_high;
  logic [39:0] shadow_total;

  outcome_t pending_results[$];
  int unsigned mismatch_count;
  int unsigned accepted_count;
  int unsigned result_count;
  int unsigned no_slot_seen;
  int unsigned no_fit_seen;
  int unsigned saturated_seen;

  function automatic logic [63:0] round_up_page(logic [63:0] v);
    logic [63:0] rem;
    rem = v % PAGE;
    return (rem != 0) ? v + PAGE - rem : v;
  endfunction

  function automatic logic [63:0] round_down_page(logic [63:0] v);
    return v - (v % PAGE);
  endfunction

  // Clip, round and insert a region into the first empty slot.
  function automatic logic [1:0] shadow_add(logic [63:0] a, logic [63:0] len);
    logic [63:0] lim;
    logic [63:0] top;
    lim = {32'd0, limit_shadow};
    if (a > lim) return ST_OK;
    if (a + len > lim) len = lim - a;
    if (len == 0) return ST_OK;
    a = round_up_page(a);
    if (a > ADDR_TOP) return ST_OK;
    if (a + len > ADDR_TOP + 1) len = ADDR_TOP + 1 - a;
    len = round_down_page(len);
    for (int m = 0; m < N_SLOTS; m++) begin
      if (shadow_len[m] != 0) continue;
      shadow_base[m] = a[31:0];
      shadow_len[m] = len[31:0];
      if (m >= shadow_used) shadow_used = m + 1;
      top = a + len;
      if (top > ADDR_TOP) top = ADDR_TOP;
      if (top[31:0] > shadow_high) shadow_high = top[31:0];
      return ST_OK;
    end
    return ST_NO_SLOT;
  endfunction

  // Remove a page-widened range from every region, keeping the leftovers.
  function automatic logic [1:0] shadow_cut(logic [63:0] lo_in, logic [63:0] hi_in);
    logic [1:0] st;
    logic [63:0] lo, hi, mb, me;
    int unsigned m;
    st = ST_OK;
    lo_in = round_down_page(lo_in);
    hi_in = round_up_page(hi_in);
    m = 0;
    // The in-use count may grow while re-adding pieces, so it is re-read.
    while (m < shadow_used && m < N_SLOTS) begin
      lo = lo_in;
      hi = hi_in;
      mb = {32'd0, shadow_base[m]};
      me = mb + shadow_len[m];
      if (lo < mb) lo = mb;
      if (hi > me) hi = me;
      if (lo < hi) begin
        shadow_base[m] = '0;
        shadow_len[m] = '0;
        if (lo > mb && shadow_add(mb, lo - mb) != ST_OK) st = ST_NO_SLOT;
        if (hi < me && shadow_add(hi, me - hi) != ST_OK) st = ST_NO_SLOT;
      end
      m++;
    end
    return st;
  endfunction

  function automatic outcome_t predict_request(logic [1:0] req, logic [31:0] b,
                                               logic [31:0] s, logic [31:0] e);
    outcome_t r;
    logic [63:0] need;
    logic [63:0] sum;
    r = '0;
    case (req)
      REQ_ADD: r.st = shadow_add({32'd0, b}, {32'd0, s});
      REQ_CUT: r.st = shadow_cut({32'd0, b}, {32'd0, e});
      REQ_ALLOC: begin
        need = round_up_page({32'd0, s});
        r.st = ST_NO_FIT;
        for (int unsigned m = 0; m < shadow_used && m < N_SLOTS; m++) begin
          if ({32'd0, shadow_len[m]} < need) continue;
          r.addr = shadow_base[m];
          shadow_base[m] = shadow_base[m] + need[31:0];
          shadow_len[m] = shadow_len[m] - need[31:0];
          sum = {24'd0, shadow_total} + need;
          shadow_total = (sum > {24'd0, TOTAL_MAX}) ? TOTAL_MAX : sum[39:0];
          r.st = ST_OK;
          break;
        end
      end
      default: r.st = ST_OK;
    endcase
    r.high = shadow_high;
    r.total = shadow_total;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h", result_count, what,
             got, want);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result checker: every done cycle is one transaction and is compared
  // field by field against the oldest expectation in the queue.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {62'd0, status}, 64'd0);
      end else begin
        outcome_t want;
        want = pending_results.pop_front();
        if (status !== want.st) report_mismatch("status", status, want.st);
        if (alloc_addr !== want.addr) report_mismatch("alloc_addr", alloc_addr, want.addr);
        if (high_mark !== want.high) report_mismatch("high_mark", high_mark, want.high);
        if (allocated_total !== want.total)
          report_mismatch("allocated_total", allocated_total, want.total);
        if (want.st == ST_NO_SLOT) no_slot_seen++;
        if (want.st == ST_NO_FIT) no_fit_seen++;
        if (want.total == TOTAL_MAX) saturated_seen++;
      end
      result_count++;
    end
  end

  // Sends one request transaction after a random idle gap. A gap of zero
  // keeps start high straight from the previous transaction, which is the
  // back-to-back case. The expectation is queued at the accepting edge.
  task automatic send_request(logic [1:0] req, logic [31:0] b, logic [31:0] s,
                              logic [31:0] e, bit known, outcome_t typed);
    int unsigned gap;
    outcome_t predicted;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    req_type <= req;
    base_addr <= b;
    size_bytes <= s;
    end_addr <= e;
    do @(posedge clk); while (busy);
    predicted = predict_request(req, b, s, e);
    pending_results.push_back(known ? typed : predicted);
    accepted_count++;
  endtask

  task automatic release_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Waits until every queued result has come back; used before any
  // register write and as the sender's full pause.
  task automatic drain_results();
    release_start();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_shadow = v;
  endtask

  // Addresses mostly land in a small window so that regions overlap and
  // cuts split them; some are fully random so every bit toggles.
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($urandom_range(0, 255) * PAGE);
      2: return 32'(32'hFFFF_F000 - $urandom_range(0, 8) * PAGE + $urandom_range(0, 4095));
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 6))
      0: return $urandom();
      1: return $urandom_range(0, 4095);
      2: return 32'd0;
      3: return 32'($urandom_range(1, 16) * PAGE);
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  directed_row_t directed_rows[$];

  function automatic directed_row_t make_row(logic [1:0] req, logic [31:0] b,
                                             logic [31:0] s, logic [31:0] e,
                                             bit known, outcome_t res);
    directed_row_t row;
    row.req = req;
    row.base = b;
    row.size = s;
    row.stop = e;
    row.known = known;
    row.res = res;
    return row;
  endfunction

  initial begin
    logic [1:0] req;
    logic [31:0] b, e;
    int unsigned pick;
    logic [31:0] phase_limits [6];

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    start = 1'b0;
    req_type = REQ_ADD;
    base_addr = '0;
    size_bytes = '0;
    end_addr = '0;
    mismatch_count = 0;
    accepted_count = 0;
    result_count = 0;
    no_slot_seen = 0;
    no_fit_seen = 0;
    saturated_seen = 0;
    limit_shadow = LIMIT_RESET;
    for (int m = 0; m < N_SLOTS; m++) begin
      shadow_base[m] = '0;
      shadow_len[m] = '0;
    end
    shadow_used = 0;
    shadow_high = '0;
    shadow_total = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The typed-in rows are the ones whose answer is obvious:
    // an empty table, ignored adds, the first stored add and the unknown request code.
    directed_rows.push_back(make_row(REQ_ALLOC, 0, 0, 0, 1, '{ST_NO_FIT, 0, 0, 0}));
    directed_rows.push_back(make_row(REQ_ALLOC, 0, 32'hFFFF_FFFF, 0, 1,
                                     '{ST_NO_FIT, 0, 0, 0}));
    directed_rows.push_back(make_row(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 1, '{ST_OK, 0, 0, 0}));
    directed_rows.push_back(make_row(REQ_ADD, 32'hFFFF_FFFF, 32'h1000, 0, 1,
                                     '{ST_OK, 0, 0, 0}));
    directed_rows.push_back(make_row(REQ_ADD, 32'h1000, 0, 0, 1, '{ST_OK, 0, 0, 0}));
    directed_rows.push_back(make_row(REQ_CUT, 0, 0, 32'hFFFF_FFFF, 1, '{ST_OK, 0, 0, 0}));
    directed_rows.push_back(make_row(REQ_ADD, 32'h1000, 32'h10000, 0, 1,
                                     '{ST_OK, 0, 32'h11000, 0}));
    directed_rows.push_back(make_row(REQ_ADD, 32'h0080_0000, 32'h800, 0, 0, '0));
    directed_rows.push_back(make_row(REQ_ADD, 32'h0002_0234, 32'h5000, 0, 0, '0));
    directed_rows.push_back(make_row(REQ_ALLOC, 0, 0, 0, 0, '0));
    directed_rows.push_back(make_row(REQ_ALLOC, 0, 1, 0, 0, '0));
    directed_rows.push_back(make_row(REQ_ALLOC, 0, 32'h3000, 0, 0, '0));
    directed_rows.push_back(make_row(REQ_CUT, 32'h4800, 0, 32'h6001, 0, '0));
    directed_rows.push_back(make_row(REQ_ALLOC, 0, 32'h9000, 0, 0, '0));
    directed_rows.push_back(make_row(REQ_ADD, 0, 32'hFFFF_FFFF, 0, 0, '0));
    directed_rows.push_back(make_row(REQ_ALLOC, 0, 32'hFFFF_E000, 0, 0, '0));
    directed_rows.push_back(make_row(REQ_CUT, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, '0));
    directed_rows.push_back(make_row(REQ_CUT, 0, 0, 32'hFFFF_FFFF, 0, '0));
    directed_rows.push_back(make_row(REQ_ALLOC, 0, 0, 0, 0, '0));
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].base, directed_rows[i].size,
                   directed_rows[i].stop, directed_rows[i].known, directed_rows[i].res);

    // Top of the address space: with the limit at its maximum, adds near
    // 4 GiB get clipped at the limit or dropped.
    drain_results();
    write_limit(32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'hFFFF_F001, 32'h10, 0, 0, '0);
    send_request(REQ_ADD, 32'hFFFF_E000, 32'hFFFF_FFFF, 0, 0, '0);
    send_request(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, '0);

    // Saturating total: repeatedly add a near-4 GiB region and allocate all
    // of it until the 40-bit byte count pins at its maximum. The emptied
    // slot is reused by the next add.
    drain_results();
    send_request(REQ_CUT, 0, 0, 32'hFFFF_FFFF, 0, '0);
    for (int i = 0; i < 260; i++) begin
      send_request(REQ_ADD, 0, 32'hFFFF_FFFF, 0, 0, '0);
      send_request(REQ_ALLOC, 0, 32'hFFFF_E001, 0, 0, '0);
    end

    // Random phases, each under its own limit.
    phase_limits[0] = LIMIT_RESET;
    phase_limits[1] = 32'd0;
    phase_limits[2] = 32'h0008_0000;
    phase_limits[3] = $urandom();
    phase_limits[4] = 32'hFFFF_FFFF;
    phase_limits[5] = 32'h0010_0FFF;
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      write_limit(phase_limits[ph]);
      for (int i = 0; i < 35; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) req = REQ_ADD;
        else if (pick < 65) req = REQ_CUT;
        else if (pick < 96) req = REQ_ALLOC;
        else req = REQ_UNKNOWN;
        b = pick_addr();
        e = ($urandom_range(0, 4) == 0) ? $urandom() : b + $urandom_range(0, 32'h8000);
        send_request(req, b, pick_size(), e, 0, '0);
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    $display("Covered %0d request transactions, %0d results, over several address limits.",
             accepted_count, result_count);
    $display("Results with no free slot: %0d, no fitting region: %0d, saturated total: %0d.",
             no_slot_seen, no_fit_seen, saturated_seen);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: generous enough for every transaction to take a worst-case cut.
  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
